[src/hsd_pkg.sv]
// Shared types, constants and helpers for the Hangul syllable decomposer.
// Used by hsd_front, hsd_fifo, hsd_back and the top level.
package hsd_pkg;

    localparam logic [15:0] SYL_FIRST    = 16'hAC00;
    localparam logic [15:0] SYL_LAST     = 16'hD7A3;
    localparam logic [15:0] INITIAL_BASE = 16'h1100;
    localparam logic [15:0] MEDIAL_BASE  = 16'h1161;
    localparam logic [15:0] FINAL_BASE   = 16'h11A7;
    localparam logic [7:0]  LEAD_MASK    = 8'hE0;
    localparam logic [7:0]  CONT_MARK    = 8'h80;
    localparam logic [7:0]  CONT_BITS    = 8'h3F;

    // Reciprocal multipliers: (s >> 2) / 7 and l / 21, exact over the syllable range
    localparam logic [12:0] RECIP_7      = 13'd4682;
    localparam int          RECIP_7_SH   = 15;
    localparam logic [8:0]  RECIP_21     = 9'd391;
    localparam int          RECIP_21_SH  = 13;

    localparam logic [3:0]  JAMO_LAST_SHORT = 4'd5;
    localparam logic [3:0]  JAMO_LAST_LONG  = 4'd8;

    // Command from the front part to the back part
    typedef struct packed {
        logic            jamo;     // 1: decompose syllable offset s
        logic            last;     // command ends the string
        logic [1:0]      nbytes;   // pass-through bytes, 1..3
        logic [13:0]     s;        // code point minus SYL_FIRST
        logic [2:0][7:0] bytes;    // pass-through bytes, index 0 first out
    } t_cmd;

    // One byte of the three-byte UTF-8 form of code point j
    function automatic logic [7:0] utf8_byte(input logic [15:0] j, input logic [1:0] pos);
        logic [7:0] b;
        unique case (pos)
            2'd0:    b = LEAD_MASK | {4'd0, j[15:12]};
            2'd1:    b = CONT_MARK | {2'd0, j[11:6]};
            default: b = CONT_MARK | {2'd0, j[5:0]};
        endcase
        return b;
    endfunction

endpackage

[src/hsd_front.sv]
// Front part: byte window, three-byte syllable test and command build.
// Depends on hsd_pkg.
module hsd_front import hsd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [1:0][7:0] r_pend, n_pend;
    logic [1:0]      r_cnt, n_cnt;
    logic            accept;
    logic            shape;
    logic [15:0]     cp;
    logic            hit;
    logic [15:0]     s_full;
    t_cmd            cmd;
    logic            has_out;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    assign shape = ((r_pend[0] & LEAD_MASK) == LEAD_MASK) && r_pend[1][7] && i_byte[7];
    assign cp    = {r_pend[0][3:0], r_pend[1][5:0], i_byte[5:0]};
    assign hit   = shape && (cp >= SYL_FIRST) && (cp <= SYL_LAST);
    assign s_full = cp - SYL_FIRST;

    always_comb begin
        n_pend  = r_pend;
        n_cnt   = r_cnt;
        has_out = 1'b0;
        cmd     = '0;
        cmd.last = i_last;
        cmd.s    = s_full[13:0];
        priority if (r_cnt == 2'd2) begin
            has_out = 1'b1;
            if (hit) begin
                cmd.jamo = 1'b1;
                n_cnt    = 2'd0;
            end else begin
                cmd.bytes[0] = r_pend[0];
                cmd.nbytes   = 2'd1;
                n_pend[0]    = r_pend[1];
                n_pend[1]    = i_byte;
                if (i_last) begin
                    // flush the slid window behind the passed byte
                    cmd.bytes[1] = r_pend[1];
                    cmd.bytes[2] = i_byte;
                    cmd.nbytes   = 2'd3;
                    n_cnt        = 2'd0;
                end
            end
        end else if (i_last) begin
            has_out      = 1'b1;
            cmd.bytes[0] = (r_cnt == 2'd1) ? r_pend[0] : i_byte;
            cmd.bytes[1] = i_byte;
            cmd.nbytes   = r_cnt + 2'd1;
            n_cnt        = 2'd0;
        end else begin
            n_pend[r_cnt[0]] = i_byte;
            n_cnt            = r_cnt + 2'd1;
        end
    end

    assign o_push = accept && has_out;
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (accept) begin
            r_cnt <= n_cnt;
        end
        if (accept) begin
            r_pend <= n_pend;
        end
    end

endmodule

[src/hsd_fifo.sv]
// Short command queue between the front and back parts.
// Depends on hsd_pkg for the command type.
module hsd_fifo import hsd_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

[src/hsd_back.sv]
// Back part: jamo index split and byte sequencer with output register.
// Depends on hsd_pkg.
module hsd_back import hsd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_cmd       i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_run_last,
    output logic       o_string_last
);

    logic [3:0]  r_idx;
    logic [1:0]  r_wait;
    logic [8:0]  r_l;
    logic [4:0]  r_ini, r_fin, r_med;
    logic        r_valid;
    logic [7:0]  r_byte;
    logic        r_run_last, r_string_last;

    logic [24:0] prod_l;
    logic [17:0] prod_i;
    logic [13:0] fin_full;
    logic [8:0]  med_full;
    logic        slot_free;
    logic        can_emit;
    logic        is_end;
    logic [7:0]  byte_out;
    logic [15:0] j;
    logic [1:0]  pos;
    logic [3:0]  last_idx;

    // Split s = 588*ini + 28*med + fin over a short register chain
    assign prod_l   = 25'(i_head.s[13:2]) * 25'(RECIP_7);
    assign prod_i   = 18'(r_l) * 18'(RECIP_21);
    assign fin_full = i_head.s - 14'(r_l) * 14'd28;
    assign med_full = r_l - 9'(r_ini) * 9'd21;

    always_ff @(posedge i_clk) begin
        r_l   <= prod_l[RECIP_7_SH +: 9];
        r_ini <= prod_i[RECIP_21_SH +: 5];
        r_fin <= fin_full[4:0];
        r_med <= med_full[4:0];
    end

    assign last_idx = (r_fin != 5'd0) ? JAMO_LAST_LONG : JAMO_LAST_SHORT;

    always_comb begin
        j   = INITIAL_BASE + 16'(r_ini);
        pos = r_idx[1:0];
        if (r_idx >= 4'd6) begin
            j   = FINAL_BASE + 16'(r_fin);
            pos = 2'(r_idx - 4'd6);
        end else if (r_idx >= 4'd3) begin
            j   = MEDIAL_BASE + 16'(r_med);
            pos = 2'(r_idx - 4'd3);
        end
    end

    always_comb begin
        if (i_head.jamo) begin
            can_emit = !i_empty && (r_wait == 2'd2);
            is_end   = (r_idx == last_idx);
            byte_out = utf8_byte(j, pos);
        end else begin
            can_emit = !i_empty;
            is_end   = (r_idx[1:0] == i_head.nbytes - 2'd1);
            byte_out = i_head.bytes[r_idx[1:0]];
        end
    end

    assign slot_free = !r_valid || i_ready;
    assign o_pop     = can_emit && slot_free && is_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_wait  <= '0;
            r_valid <= 1'b0;
        end else begin
            // wait for the index split of a fresh jamo command
            if (!i_empty && i_head.jamo && r_wait != 2'd2) begin
                r_wait <= r_wait + 2'd1;
            end
            if (can_emit && slot_free) begin
                r_valid <= 1'b1;
                if (is_end) begin
                    r_idx  <= '0;
                    r_wait <= '0;
                end else begin
                    r_idx <= r_idx + 4'd1;
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
        if (can_emit && slot_free) begin
            r_byte        <= byte_out;
            r_run_last    <= is_end;
            r_string_last <= is_end && i_head.last;
        end
    end

    assign o_valid       = r_valid;
    assign o_byte        = r_byte;
    assign o_run_last    = r_run_last;
    assign o_string_last = r_string_last;

endmodule

[src/hangul_syllable_decompose_utf8.sv]
// Top level of the streaming Hangul syllable decomposer over UTF-8 bytes.
// Instantiates hsd_front, hsd_fifo and hsd_back; depends on hsd_pkg.
//
//  channel   dir  tdata             tuser         tlast
//  s_axis    in   in_byte[7:0]      -             end_of_string
//  m_axis    out  out_byte[7:0]     string_last   run_last
//
// One input byte is taken per cycle while the command queue has room.
// The back part sends one output byte per cycle while the receiver is ready and no
// jamo index split is pending; a syllable gives 6 or 9 output bytes, which wait
// for that split, and other bytes pass through one for one.
// Reset is synchronous and active low; it empties the window and queue.
// Either side may stall; the queue and output register absorb it.
module hangul_syllable_decompose_utf8 import hsd_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,   // end_of_string
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast,   // run_last
    output logic       o_m_axis_tuser    // [0] string_last
);

    logic push, pop, full, empty;
    t_cmd cmd, head;

    hsd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (cmd)
    );

    hsd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    hsd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_head        (head),
        .o_pop         (pop),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_byte        (o_m_axis_tdata),
        .o_run_last    (o_m_axis_tlast),
        .o_string_last (o_m_axis_tuser)
    );

endmodule

[test/hsd_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for hangul_syllable_decompose_utf8: watches both stream channels,
// predicts the decomposed byte stream and compares every output transaction.
// Stand-alone; needs no package and no file.
module hsd_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,   // end_of_string
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,   // [7:0] out_byte
    input  logic       i_m_tlast,   // run_last
    input  logic       i_m_tuser,   // [0] string_last
    output int         o_errors,
    output int         o_pending,
    output int         o_beats,
    output int         o_syllables
);

    localparam logic [15:0] HANGUL_FIRST = 16'hAC00;
    localparam logic [15:0] HANGUL_LAST  = 16'hD7A3;
    localparam int          PER_LEAD     = 588;
    localparam int          PER_VOWEL    = 28;
    localparam logic [15:0] LEAD_BASE    = 16'h1100;
    localparam logic [15:0] VOWEL_BASE   = 16'h1161;
    localparam logic [15:0] TAIL_BASE    = 16'h11A7;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       string_last;
    } t_beat;

    t_beat      expected_beats[$];
    logic [7:0] step_bytes[$];
    logic [7:0] window[2];
    int         window_fill = 0;
    int         errors      = 0;
    int         beats_seen  = 0;
    int         syllables   = 0;

    function automatic void add_jamo(input logic [15:0] jamo);
        step_bytes.push_back({4'hE, jamo[15:12]});
        step_bytes.push_back({2'b10, jamo[11:6]});
        step_bytes.push_back({2'b10, jamo[5:0]});
    endfunction

    // Work out the output transactions caused by one input byte
    function automatic void decompose_byte(input logic [7:0] b, input logic eos);
        logic        shape;
        logic [15:0] cp;
        int          offset;
        t_beat       beat;
        step_bytes.delete();
        if (window_fill >= 2) begin
            shape = (window[0][7:5] == 3'b111) && window[1][7] && b[7];
            cp    = {window[0][3:0], window[1][5:0], b[5:0]};
            if (shape && cp >= HANGUL_FIRST && cp <= HANGUL_LAST) begin
                offset = int'(cp - HANGUL_FIRST);
                add_jamo(16'(LEAD_BASE + offset / PER_LEAD));
                add_jamo(16'(VOWEL_BASE + (offset % PER_LEAD) / PER_VOWEL));
                if (offset % PER_VOWEL != 0)
                    add_jamo(16'(TAIL_BASE + offset % PER_VOWEL));
                window_fill = 0;
                syllables++;
            end else begin
                // pass the oldest byte and slide the window
                step_bytes.push_back(window[0]);
                window[0] = window[1];
                window[1] = b;
            end
        end else begin
            window[window_fill] = b;
            window_fill++;
        end
        if (eos) begin
            for (int i = 0; i < window_fill; i++)
                step_bytes.push_back(window[i]);
            window_fill = 0;
        end
        foreach (step_bytes[i]) begin
            beat.data        = step_bytes[i];
            beat.run_last    = (i == step_bytes.size() - 1);
            beat.string_last = eos && beat.run_last;
            expected_beats.push_back(beat);
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_beat want;
        if (!i_rst_n) begin
            window_fill = 0;
            expected_beats.delete();
        end else begin
            // predict first so a same-edge result still finds its expectation
            if (i_s_tvalid && i_s_tready)
                decompose_byte(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                beats_seen++;
                if (expected_beats.size() == 0) begin
                    errors++;
                    $display("%0t ns: output with nothing expected: expected none, ", $time,
                             "got data=%02h run_last=%0b string_last=%0b",
                             i_m_tdata, i_m_tlast, i_m_tuser);
                end else begin
                    want = expected_beats.pop_front();
                    if (want.data !== i_m_tdata || want.run_last !== i_m_tlast ||
                        want.string_last !== i_m_tuser) begin
                        errors++;
                        $display("%0t ns: mismatch: expected data=%02h run_last=%0b ",
                                 $time, want.data, want.run_last,
                                 "string_last=%0b, got data=%02h run_last=%0b string_last=%0b",
                                 want.string_last, i_m_tdata, i_m_tlast, i_m_tuser);
                    end
                end
            end
        end
        o_errors    <= errors;
        o_pending   <= expected_beats.size();
        o_beats     <= beats_seen;
        o_syllables <= syllables;
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Testbench top for hangul_syllable_decompose_utf8: clock, reset, UTF-8 string stimulus
// with random gaps, receiver back-pressure, watchdog and verdict.
// Depends on the block's sources and on hsd_checker.
module testbench;

    localparam int ITEM_TARGET  = 430;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_START   = 150;
    localparam int HOLD_CYCLES  = 500;

    logic       clk     = 1'b0;
    logic       rst_n   = 1'b0;
    logic       s_valid = 1'b0;
    logic [7:0] s_data  = 8'h00;
    logic       s_last  = 1'b0;
    logic       m_ready = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_data;
    logic       m_last;
    logic       m_user;

    int         errors;
    int         pending;
    int         beats;
    int         syllables;
    int         sent_bytes   = 0;
    int         sent_strings = 0;
    int         idle_cycles  = 0;
    bit         burst_mode   = 1'b0;
    logic [7:0] text_bytes[$];

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    hangul_syllable_decompose_utf8 u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .o_m_axis_tuser  (m_user)
    );

    hsd_checker u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_valid),
        .i_s_tready  (s_ready),
        .i_s_tdata   (s_data),
        .i_s_tlast   (s_last),
        .i_m_tvalid  (m_valid),
        .i_m_tready  (m_ready),
        .i_m_tdata   (m_data),
        .i_m_tlast   (m_last),
        .i_m_tuser   (m_user),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_beats     (beats),
        .o_syllables (syllables)
    );

    // Three-byte sequence with chosen marker bits, so broken and loose forms come easily
    function automatic void add_seq(input logic [3:0] lead_top, input logic [1:0] mid_top,
                                    input logic [1:0] tail_top, input logic [15:0] cp);
        text_bytes.push_back({lead_top, cp[15:12]});
        text_bytes.push_back({mid_top, cp[11:6]});
        text_bytes.push_back({tail_top, cp[5:0]});
    endfunction

    // Offer one byte, idling first at random; return at the edge that takes it
    task automatic send_byte(input logic [7:0] b, input logic eos);
        int r;
        int gap;
        r   = $urandom_range(0, 99);
        gap = 0;
        if (!burst_mode) begin
            if (r >= 90)
                gap = $urandom_range(8, 30);
            else if (r >= 55)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= eos;
        do @(posedge clk); while (!s_ready);
        sent_bytes++;
    endtask

    task automatic send_text();
        foreach (text_bytes[i])
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
        text_bytes.delete();
        sent_strings++;
    endtask

    initial begin : stimulus
        int          r;
        int          tokens;
        bit          loose;
        logic [15:0] cp;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // syllable with no final jamo, ending the string on its last byte
        add_seq(4'hE, 2'b10, 2'b10, 16'hAC00);
        send_text();
        // last syllable, with final jamo, then a lone byte flushed at the end
        add_seq(4'hE, 2'b10, 2'b10, 16'hD7A3);
        text_bytes.push_back(8'h41);
        send_text();
        // loose lead and loose continuation bytes
        add_seq(4'hF, 2'b11, 2'b11, 16'hAC01);
        send_text();
        // just outside the syllable range on both sides
        add_seq(4'hE, 2'b10, 2'b10, 16'hD7A4);
        add_seq(4'hE, 2'b10, 2'b10, 16'hABFF);
        send_text();
        // short strings
        text_bytes.push_back(8'h00);
        send_text();
        text_bytes.push_back(8'hFF);
        text_bytes.push_back(8'h80);
        send_text();
        // middle byte lacks its marker bit
        add_seq(4'hE, 2'b00, 2'b10, 16'hAC00);
        send_text();
        // zero bytes are plain data
        burst_mode = 1'b1;
        repeat (3) text_bytes.push_back(8'h00);
        send_text();

        while (sent_bytes < ITEM_TARGET) begin
            burst_mode = ($urandom_range(0, 3) == 0);
            tokens     = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20)
                                                     : $urandom_range(1, 6);
            repeat (tokens) begin
                r  = $urandom_range(0, 99);
                cp = 16'($urandom_range(16'hAC00, 16'hD7A3));
                if (r < 45) begin
                    loose = ($urandom_range(0, 9) == 0);
                    if (loose)
                        add_seq(4'hF, {1'b1, 1'($urandom)}, {1'b1, 1'($urandom)}, cp);
                    else
                        add_seq(4'hE, 2'b10, 2'b10, cp);
                end else if (r < 60) begin
                    text_bytes.push_back(8'($urandom_range(0, 127)));
                end else if (r < 70) begin
                    add_seq(4'hE, 2'b10, 2'b10, 16'($urandom));
                end else if (r < 80) begin
                    // truncated syllable
                    text_bytes.push_back({4'hE, cp[15:12]});
                    if ($urandom_range(0, 1) == 1)
                        text_bytes.push_back({2'b10, cp[11:6]});
                end else if (r < 88) begin
                    text_bytes.push_back({3'b110, 5'($urandom)});
                    text_bytes.push_back({2'b10, 6'($urandom)});
                end else if (r < 94) begin
                    add_seq(4'($urandom), 2'($urandom), 2'($urandom), cp);
                end else begin
                    text_bytes.push_back(8'($urandom));
                end
            end
            send_text();
        end
        s_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d bytes in %0d strings; %0d syllables were split into jamo.",
                 sent_bytes, sent_strings, syllables);
        $display("Checked %0d output bytes, with random gaps and a %0d-cycle receiver hold.",
                 beats, HOLD_CYCLES);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin : receiver
        int mode;
        int len;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        repeat (HOLD_START) begin
            m_ready <= ($urandom_range(0, 3) != 0);
            @(posedge clk);
        end
        // hold off long enough for the block to fill and stall its input
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        forever begin
            mode = $urandom_range(0, 9);
            len  = $urandom_range(8, 60);
            repeat (len) begin
                if (mode < 3)
                    m_ready <= 1'b1;
                else if (mode < 9)
                    m_ready <= ($urandom_range(0, 3) != 0);
                else
                    m_ready <= 1'b0;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

[hangul_syllable_decompose_utf8.f]
src/hsd_pkg.sv
src/hsd_front.sv
src/hsd_fifo.sv
src/hsd_back.sv
src/hangul_syllable_decompose_utf8.sv
test/hsd_checker.sv
test/testbench.sv
